// ----- rtl/slbbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Status LED sequencer package
// Command codes, timing constants and the colour sequence table shared by
// the status LED sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package slbbc_pkg;

  // Command codes carried on the func field
  typedef enum logic [2:0] {
    FUNC_TICK      = 3'd0,
    FUNC_BLINK     = 3'd1,
    FUNC_SEQUENCE  = 3'd2,
    FUNC_STOP      = 3'd3,
    FUNC_COLOUR    = 3'd4,
    FUNC_LOW_BATT  = 3'd5,
    FUNC_READY     = 3'd6,
    FUNC_NOP       = 3'd7
  } func_t;

  typedef logic [23:0] colour_t;

  // Pattern timing (milliseconds)
  localparam int unsigned BREATH_PERIOD_MS = 2000;
  localparam int unsigned BREATH_HALF_MS   = BREATH_PERIOD_MS / 2;
  localparam int unsigned BREATH_FRAME_MS  = 30;
  localparam int unsigned BREATH_SPAN      = 247;
  localparam int unsigned BREATH_FLOOR     = 8;
  localparam int unsigned IDLE_CLEAR_MS    = 1000;
  localparam int unsigned SEQ_PERIOD_MS    = 50;
  localparam int unsigned SEQ_COUNT        = 6;
  localparam int unsigned FORCE_FRAMES     = 8;
  localparam int unsigned AFTER_CLEARS     = 30;

  // Reciprocal of the half period at 2^-28 scale, pre-multiplied by the span:
  // (tri * BREATH_MULT) >> 28 equals span * tri / half exactly for tri <= half
  localparam int unsigned BREATH_SHIFT = 28;
  localparam int unsigned BREATH_RECIP = ((1 << BREATH_SHIFT) + BREATH_HALF_MS - 1)
                                         / BREATH_HALF_MS;
  localparam longint unsigned BREATH_MULT = longint'(BREATH_SPAN) * BREATH_RECIP;

  localparam colour_t RESET_COLOUR = 24'hFF0000;
  localparam colour_t READY_COLOUR = 24'h00FF00;

  // Colour of one step of the colour sequence
  function automatic colour_t seq_colour(input logic [2:0] idx);
    colour_t c;
    unique case (idx)
      3'd0, 3'd1: c = 24'hFF0000;
      3'd2, 3'd3: c = 24'hFFB400;
      3'd4, 3'd5: c = 24'h00FF00;
      default:    c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/status_led_blink_breathe_controller_top.sv -----
// ----------------------------------------------------------------------------
// Status LED sequencer
// Blink, colour sequence, idle clear and low-battery breathing for a strip
// lit in one colour, driven by millisecond ticks and command words.
// ----------------------------------------------------------------------------
// Every input word (a tick or a command) yields exactly one result word: the
// colour for the whole strip, a refresh frame count and the mode flags after
// the word. A word is taken combinationally and its result is registered, so the
// block accepts one word per clock; the result register stalls input only
// while a result waits and out_ready is low. The breathing phase is kept as a
// running counter modulo the 2 s period, so no divider sits in the tick path.
`default_nettype none

module status_led_blink_breathe_controller_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_func,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [15:0] in_duration_ms,
  input  wire logic [7:0]  in_blink_total,
  input  wire logic        in_active,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_show,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [3:0]       out_refresh_count,
  output logic             out_blinking,
  output logic             out_low_battery,
  output logic [4:0]       out_pending_clears
);

  import slbbc_pkg::*;

  localparam logic [31:0] BREATH_DUE_M1 = 32'(BREATH_FRAME_MS - 1);
  localparam logic [31:0] IDLE_DUE_M1   = 32'(IDLE_CLEAR_MS - 1);
  localparam logic [10:0] PHASE_LAST    = 11'(BREATH_PERIOD_MS - 1);
  localparam logic [10:0] PHASE_HALF    = 11'(BREATH_HALF_MS);
  localparam logic [10:0] PHASE_FULL    = 11'(BREATH_PERIOD_MS);
  localparam logic [2:0]  SEQ_LAST      = 3'(SEQ_COUNT - 1);

  // Sequencer state
  logic [31:0] now_r, now_nxt;
  logic [31:0] last_blink_r, last_blink_nxt;
  logic [31:0] last_breath_r, last_breath_nxt;
  logic [31:0] breath_age_r, breath_age_nxt;
  logic [10:0] breath_phase_r, breath_phase_nxt;
  logic [31:0] last_idle_r, last_idle_nxt;
  logic        phase_on_r, phase_on_nxt;
  logic [7:0]  blink_done_r, blink_done_nxt;
  logic [2:0]  seq_idx_r, seq_idx_nxt;
  logic        blinking_r, blinking_nxt;
  colour_t     blink_colour_r, blink_colour_nxt;
  logic [15:0] blink_period_r, blink_period_nxt;
  logic [7:0]  blink_limit_r, blink_limit_nxt;
  logic        seq_mode_r, seq_mode_nxt;
  logic [4:0]  clears_r, clears_nxt;
  logic        ready_flag_r, ready_flag_nxt;
  logic        batt_low_r, batt_low_nxt;

  // Result register
  logic        out_valid_r;
  logic        show_r, show_nxt;
  colour_t     colour_r, colour_nxt;
  logic [3:0]  count_r, count_nxt;

  logic        accept;
  func_t       func;
  colour_t     in_colour;
  logic        cmd_ok;

  logic [31:0] now_inc;
  logic [31:0] breath_age_inc;
  logic [31:0] d_breath, d_idle, d_blink;
  logic [15:0] period_m1;
  logic        breath_due, idle_due, blink_due;
  logic [10:0] tri_val;
  logic [35:0] level_prod;
  logic [7:0]  level;
  logic [7:0]  done_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign func      = func_t'(in_func);
  assign in_colour = {in_red, in_green, in_blue};
  assign cmd_ok    = ready_flag_r && !batt_low_r;

  // Elapsed-time tests against the advanced clock: (now+1 - t) >= K
  assign now_inc    = now_r + 32'd1;
  assign d_breath   = now_r - last_breath_r;
  assign d_idle     = now_r - last_idle_r;
  assign d_blink    = now_r - last_blink_r;
  assign period_m1  = blink_period_r - 16'd1;
  assign breath_due = (d_breath >= BREATH_DUE_M1) && (d_breath != '1);
  assign idle_due   = (d_idle >= IDLE_DUE_M1) && (d_idle != '1);
  assign blink_due  = (blink_period_r == '0) ||
                      ((d_blink >= {16'd0, period_m1}) && (d_blink != '1));

  // Breathing phase: time since breathing start, modulo the period
  assign breath_age_inc = breath_age_r + 32'd1;
  always_comb begin
    if (breath_age_inc == '0) begin
      breath_phase_nxt = '0;
    end else if (breath_phase_r == PHASE_LAST) begin
      breath_phase_nxt = '0;
    end else begin
      breath_phase_nxt = breath_phase_r + 11'd1;
    end
  end

  // Triangle wave scaled to the red level
  assign tri_val    = (breath_phase_nxt <= PHASE_HALF) ? breath_phase_nxt
                                                       : PHASE_FULL - breath_phase_nxt;
  assign level_prod = 36'(tri_val[9:0]) * 36'(BREATH_MULT);
  assign level      = level_prod[BREATH_SHIFT +: 8] + 8'(BREATH_FLOOR);

  assign done_inc = (blink_done_r == 8'hFF) ? blink_done_r : blink_done_r + 8'd1;

  // Next state and result for the word at the input
  always_comb begin
    now_nxt          = now_r;
    last_blink_nxt   = last_blink_r;
    last_breath_nxt  = last_breath_r;
    breath_age_nxt   = breath_age_r;
    last_idle_nxt    = last_idle_r;
    phase_on_nxt     = phase_on_r;
    blink_done_nxt   = blink_done_r;
    seq_idx_nxt      = seq_idx_r;
    blinking_nxt     = blinking_r;
    blink_colour_nxt = blink_colour_r;
    blink_period_nxt = blink_period_r;
    blink_limit_nxt  = blink_limit_r;
    seq_mode_nxt     = seq_mode_r;
    clears_nxt       = clears_r;
    ready_flag_nxt   = ready_flag_r;
    batt_low_nxt     = batt_low_r;
    show_nxt         = 1'b0;
    colour_nxt       = '0;
    count_nxt        = '0;

    unique case (func)
      FUNC_TICK: begin
        now_nxt        = now_inc;
        breath_age_nxt = breath_age_inc;
        if (batt_low_r) begin
          // breathing frame every 30 ms
          if (breath_due) begin
            last_breath_nxt = now_inc;
            show_nxt        = 1'b1;
            colour_nxt      = {level, 16'h0000};
            count_nxt       = 4'd1;
          end
        end else if (!blinking_r) begin
          // drain pending clears, then idle clear once a second
          if (clears_r != '0) begin
            clears_nxt    = clears_r - 5'd1;
            last_idle_nxt = now_inc;
            show_nxt      = 1'b1;
            count_nxt     = 4'd1;
          end else if (idle_due) begin
            last_idle_nxt = now_inc;
            show_nxt      = 1'b1;
            count_nxt     = 4'd1;
          end
        end else if (blink_due) begin
          last_blink_nxt = now_inc;
          show_nxt       = 1'b1;
          count_nxt      = 4'd1;
          if (!phase_on_r) begin
            colour_nxt   = seq_mode_r ? seq_colour(seq_idx_r) : blink_colour_r;
            phase_on_nxt = 1'b1;
          end else begin
            phase_on_nxt = 1'b0;
            if (done_inc >= blink_limit_r) begin
              // blink end: forced black frames, then pending clears
              blinking_nxt   = 1'b0;
              blink_done_nxt = '0;
              seq_idx_nxt    = '0;
              clears_nxt     = 5'(AFTER_CLEARS);
              last_idle_nxt  = '0;
              count_nxt      = 4'(1 + FORCE_FRAMES);
            end else begin
              blink_done_nxt = done_inc;
              seq_idx_nxt    = (seq_idx_r == SEQ_LAST) ? 3'd0 : seq_idx_r + 3'd1;
            end
          end
        end
      end
      FUNC_BLINK, FUNC_SEQUENCE: begin
        if (cmd_ok) begin
          if (func == FUNC_BLINK) begin
            blink_colour_nxt = in_colour;
            blink_period_nxt = in_duration_ms;
            blink_limit_nxt  = in_blink_total;
            seq_mode_nxt     = 1'b0;
          end else begin
            blink_period_nxt = 16'(SEQ_PERIOD_MS);
            blink_limit_nxt  = 8'(SEQ_COUNT);
            seq_mode_nxt     = 1'b1;
          end
          blink_done_nxt = '0;
          seq_idx_nxt    = '0;
          phase_on_nxt   = 1'b0;
          clears_nxt     = '0;
          last_idle_nxt  = '0;
          blinking_nxt   = 1'b1;
          last_blink_nxt = now_r;
        end
      end
      FUNC_STOP: begin
        blinking_nxt   = 1'b0;
        blink_done_nxt = '0;
        seq_idx_nxt    = '0;
        phase_on_nxt   = 1'b0;
        clears_nxt     = '0;
        last_idle_nxt  = '0;
        show_nxt       = 1'b1;
        count_nxt      = 4'(FORCE_FRAMES);
      end
      FUNC_COLOUR: begin
        if (cmd_ok) begin
          show_nxt   = 1'b1;
          colour_nxt = in_colour;
          count_nxt  = 4'd1;
        end
      end
      FUNC_LOW_BATT: begin
        if (batt_low_r != in_active) begin
          batt_low_nxt    = in_active;
          blinking_nxt    = 1'b0;
          blink_done_nxt  = '0;
          seq_idx_nxt     = '0;
          phase_on_nxt    = 1'b0;
          last_breath_nxt = '0;
          breath_age_nxt  = '0;
          clears_nxt      = '0;
          last_idle_nxt   = '0;
          show_nxt        = 1'b1;
          count_nxt       = 4'(FORCE_FRAMES);
        end
      end
      FUNC_READY: begin
        if (!ready_flag_r) begin
          ready_flag_nxt = 1'b1;
          if (!batt_low_r) begin
            blink_colour_nxt = READY_COLOUR;
            blink_period_nxt = 16'(SEQ_PERIOD_MS);
            blink_limit_nxt  = 8'(SEQ_COUNT);
            seq_mode_nxt     = 1'b0;
            blink_done_nxt   = '0;
            seq_idx_nxt      = '0;
            phase_on_nxt     = 1'b0;
            clears_nxt       = '0;
            last_idle_nxt    = '0;
            blinking_nxt     = 1'b1;
            last_blink_nxt   = now_r;
          end
        end
      end
      default: begin
        // no operation
      end
    endcase
  end

  // Keep the phase counter in step with the breathing age
  logic [10:0] phase_sel;
  always_comb begin
    if (func == FUNC_TICK) begin
      phase_sel = breath_phase_nxt;
    end else if (func == FUNC_LOW_BATT && batt_low_r != in_active) begin
      phase_sel = '0;
    end else begin
      phase_sel = breath_phase_r;
    end
  end

  // Advance state on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r          <= '0;
      last_blink_r   <= '0;
      last_breath_r  <= '0;
      breath_age_r   <= '0;
      breath_phase_r <= '0;
      last_idle_r    <= '0;
      phase_on_r     <= 1'b0;
      blink_done_r   <= '0;
      seq_idx_r      <= '0;
      blinking_r     <= 1'b0;
      blink_colour_r <= RESET_COLOUR;
      blink_period_r <= 16'd200;
      blink_limit_r  <= 8'd3;
      seq_mode_r     <= 1'b0;
      clears_r       <= '0;
      ready_flag_r   <= 1'b0;
      batt_low_r     <= 1'b0;
    end else if (accept) begin
      now_r          <= now_nxt;
      last_blink_r   <= last_blink_nxt;
      last_breath_r  <= last_breath_nxt;
      breath_age_r   <= breath_age_nxt;
      breath_phase_r <= phase_sel;
      last_idle_r    <= last_idle_nxt;
      phase_on_r     <= phase_on_nxt;
      blink_done_r   <= blink_done_nxt;
      seq_idx_r      <= seq_idx_nxt;
      blinking_r     <= blinking_nxt;
      blink_colour_r <= blink_colour_nxt;
      blink_period_r <= blink_period_nxt;
      blink_limit_r  <= blink_limit_nxt;
      seq_mode_r     <= seq_mode_nxt;
      clears_r       <= clears_nxt;
      ready_flag_r   <= ready_flag_nxt;
      batt_low_r     <= batt_low_nxt;
    end
  end

  // Result word valid: set on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result payload until the next accepted word
  logic        res_blinking_r;
  logic        res_batt_r;
  logic [4:0]  res_clears_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      show_r         <= show_nxt;
      colour_r       <= colour_nxt;
      count_r        <= count_nxt;
      res_blinking_r <= blinking_nxt;
      res_batt_r     <= batt_low_nxt;
      res_clears_r   <= clears_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_show           = show_r;
  assign out_red            = colour_r[23:16];
  assign out_green          = colour_r[15:8];
  assign out_blue           = colour_r[7:0];
  assign out_refresh_count  = count_r;
  assign out_blinking       = res_blinking_r;
  assign out_low_battery    = res_batt_r;
  assign out_pending_clears = res_clears_r;

endmodule

`default_nettype wire

// ----- tb/status_led_blink_breathe_controller_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Status LED sequencer testbench
// Drives tick and command words through the valid/ready input channel with
// bursty gaps, stalls the result channel on its own pattern, and compares
// every result word field by field against a cycle-free model of the blink,
// colour sequence, idle clear and low-battery breathing engine.
// ----------------------------------------------------------------------------

module status_led_blink_breathe_controller_top_test;
  import slbbc_pkg::*;

  // One command or tick word
  typedef struct packed {
    func_t       func;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] duration_ms;
    logic [7:0]  blink_total;
    logic        active;
  } led_word_t;

  // One strip update word
  typedef struct packed {
    logic       show;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] refresh_count;
    logic       blinking;
    logic       low_battery;
    logic [4:0] pending_clears;
  } led_frame_t;

  // Model of the LED engine plus the queue of strip updates still owed
  class led_scoreboard;
    bit [31:0]  ms_clock, blink_mark_ms, breath_mark_ms, breath_origin_ms, idle_mark_ms;
    bit [23:0]  blink_rgb;
    bit [15:0]  phase_len;
    bit [7:0]   cycles_done, cycles_limit;
    bit [4:0]   clears_pending;
    bit         lit_phase, blink_running, seq_mode, system_ready, battery_low;
    bit [23:0]  seq_rgb [6] = '{24'hFF0000, 24'hFF0000, 24'hFFB400,
                                24'hFFB400, 24'h00FF00, 24'h00FF00};
    led_frame_t frames_due [$];
    int         failures;

    function new();
      ms_clock = '0; blink_mark_ms = '0; breath_mark_ms = '0;
      breath_origin_ms = '0; idle_mark_ms = '0;
      blink_rgb = RESET_COLOUR; phase_len = 16'd200; cycles_limit = 8'd3;
      cycles_done = '0; clears_pending = '0;
      lit_phase = 0; blink_running = 0; seq_mode = 0;
      system_ready = 0; battery_low = 0;
      failures = 0;
    endfunction

    function led_frame_t lit_frame(bit [23:0] rgb, bit [3:0] count);
      led_frame_t f;
      f = '0;
      f.show = 1'b1;
      {f.red, f.green, f.blue} = rgb;
      f.refresh_count = count;
      return f;
    endfunction

    // Start a blink run, unless the system is not up or the battery is low
    function void arm_blink(bit [23:0] rgb, bit [15:0] period, bit [7:0] limit, bit seq);
      if (!system_ready || battery_low) return;
      blink_rgb = rgb;
      phase_len = period;
      cycles_limit = limit;
      seq_mode = seq;
      cycles_done = '0;
      lit_phase = 0;
      clears_pending = '0;
      idle_mark_ms = '0;
      blink_running = 1;
      blink_mark_ms = ms_clock;
    endfunction

    // End any blink and drop pending clears
    function void drop_blink();
      blink_running = 0;
      cycles_done = '0;
      lit_phase = 0;
      clears_pending = '0;
      idle_mark_ms = '0;
    endfunction

    // Work out the strip update owed for an accepted word
    function void note_word(led_word_t w);
      led_frame_t  f;
      int unsigned cycle_pos, ramp;
      bit [7:0]    level;
      f = '0;
      case (w.func)
        FUNC_TICK: begin
          ms_clock = ms_clock + 1;
          if (battery_low) begin
            if (ms_clock - breath_mark_ms >= BREATH_FRAME_MS) begin
              breath_mark_ms = ms_clock;
              cycle_pos = (ms_clock - breath_origin_ms) % BREATH_PERIOD_MS;
              ramp = (cycle_pos <= BREATH_HALF_MS) ? cycle_pos : BREATH_PERIOD_MS - cycle_pos;
              level = 8'(BREATH_FLOOR + BREATH_SPAN * ramp / BREATH_HALF_MS);
              f = lit_frame({level, 16'h0000}, 4'd1);
            end
          end else if (!blink_running) begin
            if (clears_pending != 0) begin
              clears_pending = clears_pending - 1;
              idle_mark_ms = ms_clock;
              f = lit_frame(24'h0, 4'd1);
            end else if (ms_clock - idle_mark_ms >= IDLE_CLEAR_MS) begin
              idle_mark_ms = ms_clock;
              f = lit_frame(24'h0, 4'd1);
            end
          end else if (ms_clock - blink_mark_ms >= 32'(phase_len)) begin
            blink_mark_ms = ms_clock;
            if (!lit_phase) begin
              f = lit_frame(seq_mode ? seq_rgb[cycles_done % SEQ_COUNT] : blink_rgb, 4'd1);
              lit_phase = 1;
            end else begin
              lit_phase = 0;
              if (cycles_done != 8'hFF) cycles_done = cycles_done + 1;
              // last off phase: black plus forced clears, then trailing clears
              if (cycles_done >= cycles_limit) begin
                blink_running = 0;
                cycles_done = '0;
                clears_pending = 5'(AFTER_CLEARS);
                idle_mark_ms = '0;
                f = lit_frame(24'h0, 4'(FORCE_FRAMES + 1));
              end else begin
                f = lit_frame(24'h0, 4'd1);
              end
            end
          end
        end
        FUNC_BLINK:
          arm_blink({w.red, w.green, w.blue}, w.duration_ms, w.blink_total, 1'b0);
        FUNC_SEQUENCE:
          arm_blink(blink_rgb, 16'(SEQ_PERIOD_MS), 8'(SEQ_COUNT), 1'b1);
        FUNC_STOP: begin
          drop_blink();
          f = lit_frame(24'h0, 4'(FORCE_FRAMES));
        end
        FUNC_COLOUR:
          if (system_ready && !battery_low) f = lit_frame({w.red, w.green, w.blue}, 4'd1);
        FUNC_LOW_BATT:
          if (battery_low != w.active) begin
            battery_low = w.active;
            drop_blink();
            breath_mark_ms = '0;
            breath_origin_ms = ms_clock;
            f = lit_frame(24'h0, 4'(FORCE_FRAMES));
          end
        FUNC_READY:
          if (!system_ready) begin
            system_ready = 1;
            arm_blink(READY_COLOUR, 16'(SEQ_PERIOD_MS), 8'(SEQ_COUNT), 1'b0);
          end
        default: ;
      endcase
      f.blinking = blink_running;
      f.low_battery = battery_low;
      f.pending_clears = clears_pending;
      frames_due.push_back(f);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Compare a delivered word with the oldest one owed
    function void check_frame(led_frame_t got);
      led_frame_t want;
      if (frames_due.size() == 0) begin
        $error("result word with nothing expected");
        failures++;
        return;
      end
      want = frames_due.pop_front();
      check_field("show", want.show, got.show);
      check_field("out_red", want.red, got.red);
      check_field("out_green", want.green, got.green);
      check_field("out_blue", want.blue, got.blue);
      check_field("refresh_count", want.refresh_count, got.refresh_count);
      check_field("blinking", want.blinking, got.blinking);
      check_field("low_battery", want.low_battery, got.low_battery);
      check_field("pending_clears", want.pending_clears, got.pending_clears);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_func = FUNC_NOP;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic [15:0] in_duration_ms = '0;
  logic [7:0]  in_blink_total = '0;
  logic        in_active = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_show;
  logic [7:0]  out_red, out_green, out_blue;
  logic [3:0]  out_refresh_count;
  logic        out_blinking, out_low_battery;
  logic [4:0]  out_pending_clears;

  led_scoreboard sb = new();
  int            items_sent = 0;
  int            burst_left = 0;
  int            rx_mode = 0;
  int            rx_left = 0;
  int            rx_pos = 0;
  logic [7:0]    rx_mask = 8'hFF;

  status_led_blink_breathe_controller_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_duration_ms     (in_duration_ms),
    .in_blink_total     (in_blink_total),
    .in_active          (in_active),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_show           (out_show),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .out_refresh_count  (out_refresh_count),
    .out_blinking       (out_blinking),
    .out_low_battery    (out_low_battery),
    .out_pending_clears (out_pending_clears)
  );

  always #10 clk = ~clk;

  // Watch both handshakes with the values held before the edge
  always @(posedge clk) begin
    led_word_t  w;
    led_frame_t f;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        w = {func_t'(in_func), in_red, in_green, in_blue, in_duration_ms,
             in_blink_total, in_active};
        sb.note_word(w);
      end
      if (out_valid && out_ready) begin
        f = {out_show, out_red, out_green, out_blue, out_refresh_count,
             out_blinking, out_low_battery, out_pending_clears};
        sb.check_frame(f);
      end
    end
  end

  // Receiver: switch between free running, coin-toss, mask and light stalls
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(32, 256);
      rx_mask = 8'($urandom) | 8'h01;
    end else begin
      rx_left--;
    end
    rx_pos = (rx_pos + 1) % 8;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom);
      2:       out_ready <= rx_mask[rx_pos];
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic led_word_t random_word(func_t f);
    led_word_t w;
    w.func = f;
    w.red = 8'($urandom);
    w.green = 8'($urandom);
    w.blue = 8'($urandom);
    w.duration_ms = 16'($urandom);
    w.blink_total = 8'($urandom);
    w.active = 1'($urandom);
    return w;
  endfunction

  // Offer one word and hold it until taken; close a burst with a gap
  task automatic send_word(input led_word_t w);
    in_valid <= 1'b1;
    in_func <= w.func;
    in_red <= w.red;
    in_green <= w.green;
    in_blue <= w.blue;
    in_duration_ms <= w.duration_ms;
    in_blink_total <= w.blink_total;
    in_active <= w.active;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(random_word(FUNC_TICK));
  endtask

  task automatic send_cmd(input func_t f);
    send_word(random_word(f));
  endtask

  task automatic set_battery(input bit low);
    led_word_t w;
    w = random_word(FUNC_LOW_BATT);
    w.active = low;
    send_word(w);
  endtask

  task automatic send_colour(input func_t f, input bit [23:0] rgb);
    led_word_t w;
    w = random_word(f);
    {w.red, w.green, w.blue} = rgb;
    send_word(w);
  endtask

  task automatic send_blink(input bit [23:0] rgb, input bit [15:0] dur, input bit [7:0] total);
    led_word_t w;
    w = random_word(FUNC_BLINK);
    {w.red, w.green, w.blue} = rgb;
    w.duration_ms = dur;
    w.blink_total = total;
    send_word(w);
  endtask

  initial begin
    int unsigned dur, total, n;
    burst_left = $urandom_range(0, 30);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Blink, sequence and colour commands ignored before the system is up, then the ready blink
    send_ticks(1);
    send_blink(24'hFFFFFF, 16'hFFFF, 8'hFF);
    send_cmd(FUNC_SEQUENCE);
    send_colour(FUNC_COLOUR, 24'hFFFFFF);
    send_word('{FUNC_NOP, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1});
    send_cmd(FUNC_STOP);
    set_battery(1'b0);
    send_cmd(FUNC_READY);
    send_cmd(FUNC_READY);
    send_colour(FUNC_COLOUR, 24'hFFFFFF);
    send_colour(FUNC_COLOUR, 24'h000000);
    // Low battery blocks blink and colour; same value twice does nothing
    set_battery(1'b1);
    send_blink(24'h00FF00, 16'd1, 8'd1);
    send_colour(FUNC_COLOUR, 24'h123456);
    send_ticks(1);
    set_battery(1'b1);
    set_battery(1'b0);
    // Zero count still runs one on and one off phase, then the clears
    send_blink(24'hFF00FF, 16'd0, 8'd0);
    send_ticks(4);
    send_blink(24'hFFFFFF, 16'hFFFF, 8'hFF);
    send_ticks(2);
    send_cmd(FUNC_STOP);

    // Random scenarios with random content, plus some noise
    while (items_sent < 560) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if (sb.battery_low && $urandom_range(0, 3) != 0) set_battery(1'b0);
          if ($urandom_range(0, 7) == 0) begin
            send_cmd(FUNC_BLINK);
            send_ticks($urandom_range(1, 10));
            send_cmd(FUNC_STOP);
          end else begin
            dur = $urandom_range(0, 6);
            total = $urandom_range(0, 4);
            send_blink(24'($urandom), 16'(dur), 8'(total));
            n = 2 * ((total == 0) ? 1 : total) * (dur + 1) + $urandom_range(0, 40);
            if ($urandom_range(0, 3) == 0) begin
              send_ticks($urandom_range(0, n));
              send_cmd($urandom_range(0, 1) ? FUNC_STOP : FUNC_COLOUR);
            end
            send_ticks(n);
          end
        end
        4: begin
          send_cmd(FUNC_SEQUENCE);
          send_ticks($urandom_range(40, 200));
          send_cmd(FUNC_STOP);
        end
        5: begin
          set_battery(1'b1);
          send_ticks($urandom_range(30, 150));
          if ($urandom_range(0, 3) == 0) set_battery(1'b1);
          set_battery(1'b0);
        end
        6: send_cmd(FUNC_COLOUR);
        7: send_cmd(FUNC_STOP);
        default:
          repeat ($urandom_range(1, 4)) send_word(random_word(func_t'($urandom_range(0, 7))));
      endcase
    end

    // Drain, then let the result register settle
    in_valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.failures == 0 && sb.frames_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #(10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- status_led_blink_breathe_controller_top.f -----
rtl/slbbc_pkg.sv
rtl/status_led_blink_breathe_controller_top.sv
tb/status_led_blink_breathe_controller_top_test.sv
